// File: rtl/hdlc_tx_pkg.sv
// Package for the HDLC frame transmitter: line constants, bit kinds and phase codes.
// Depends on nothing; used by hdlc_frame_transmitter.
package hdlc_tx_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [2:0]  STUFF_RUN  = 3'd5;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_FLAG  = 2'd0;
    localparam t_kind KIND_DATA  = 2'd1;
    localparam t_kind KIND_STUFF = 2'd2;
    localparam t_kind KIND_FCS   = 2'd3;

    typedef logic [1:0] t_phase;

    localparam t_phase PH_OPEN  = 2'd0;
    localparam t_phase PH_DATA  = 2'd1;
    localparam t_phase PH_FCS   = 2'd2;
    localparam t_phase PH_CLOSE = 2'd3;

endpackage

// File: rtl/hdlc_frame_transmitter.sv
// HDLC / AX.25 frame transmitter: serializes frame bytes into flagged, stuffed line bits.
// Depends on hdlc_tx_pkg.
//
// With the serializer idle, an accepted word passes the holding register and the serializer
// state before its first line bit is registered; otherwise that bit follows the previous word's
// last bit with no gap. Throughput: one line bit per cycle while the output side is ready; a word
// is 8 data bits plus up to two stuffed zeros, and a frame adds its flags, FCS and stuffed zeros.
// The rate is set by the one-bit-per-cycle serializer feeding the output register.
// Reset (synchronous, active low) closes any open frame, empties the holding and output
// registers, clears the ones counter and presets the CRC to all ones.
module hdlc_frame_transmitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [0] line_bit, [7:1] zero
    output logic [1:0] o_m_tuser,   // [1:0] bit_kind
    output logic       o_m_tlast    // run_end
);

    // Holding register: takes the next word while the current one is still shifting out.
    logic       r_hold_valid, n_hold_valid;
    logic [7:0] r_hold_data;
    logic       r_hold_last;

    // Serializer state.
    logic                 r_busy, n_busy;
    hdlc_tx_pkg::t_phase  r_phase, n_phase;
    logic [3:0]           r_idx, n_idx;
    logic [15:0]          r_shift, n_shift;     // data byte, later the FCS
    logic                 r_last, n_last;
    logic                 r_in_frame, n_in_frame;
    logic [2:0]           r_ones, n_ones;
    logic [15:0]          r_crc, n_crc;
    logic                 r_stuff_pend, n_stuff_pend;
    logic                 r_pend_end, n_pend_end;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_bit, n_out_bit;
    hdlc_tx_pkg::t_kind   r_out_kind, n_out_kind;
    logic                 r_out_end, n_out_end;

    logic        adv;
    logic        load;
    logic        cur_bit;
    logic        done;
    logic        fb;
    logic [15:0] crc_next;
    logic [2:0]  ones_inc;

    assign o_s_tready = !r_hold_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_bit};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_end;

    // The serializer produces a bit whenever the output register is free or being drained.
    assign adv = r_busy && (!r_out_valid || i_m_tready);

    always_comb begin
        n_busy       = r_busy;
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_shift      = r_shift;
        n_last       = r_last;
        n_in_frame   = r_in_frame;
        n_ones       = r_ones;
        n_crc        = r_crc;
        n_stuff_pend = r_stuff_pend;
        n_pend_end   = r_pend_end;
        n_out_valid  = r_out_valid;
        n_out_bit    = r_out_bit;
        n_out_kind   = r_out_kind;
        n_out_end    = r_out_end;
        n_hold_valid = r_hold_valid;

        cur_bit  = 1'b0;
        done     = 1'b0;
        fb       = r_crc[0] ^ r_shift[0];
        crc_next = {1'b0, r_crc[15:1]} ^ (fb ? hdlc_tx_pkg::CRC_POLY : 16'h0000);
        ones_inc = r_ones + 3'd1;

        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (adv) begin
            n_out_valid = 1'b1;
            if (r_stuff_pend) begin
                // Zero inserted after five ones; it may close the word's run.
                n_out_bit    = 1'b0;
                n_out_kind   = hdlc_tx_pkg::KIND_STUFF;
                n_out_end    = r_pend_end;
                n_stuff_pend = 1'b0;
                n_ones       = 3'd0;
                n_busy       = !r_pend_end;
            end else begin
                case (r_phase)
                    hdlc_tx_pkg::PH_OPEN, hdlc_tx_pkg::PH_CLOSE: begin
                        cur_bit    = hdlc_tx_pkg::FLAG_BYTE[r_idx[2:0]];
                        n_out_kind = hdlc_tx_pkg::KIND_FLAG;
                        n_idx      = r_idx + 4'd1;
                        if (r_idx[2:0] == 3'd7) begin
                            n_ones = 3'd0;
                            n_idx  = 4'd0;
                            if (r_phase == hdlc_tx_pkg::PH_OPEN) begin
                                n_phase = hdlc_tx_pkg::PH_DATA;
                            end else begin
                                // Closing flag done: the frame is closed.
                                done       = 1'b1;
                                n_in_frame = 1'b0;
                                n_crc      = hdlc_tx_pkg::CRC_PRESET;
                            end
                        end
                    end
                    hdlc_tx_pkg::PH_DATA: begin
                        cur_bit    = r_shift[0];
                        n_out_kind = hdlc_tx_pkg::KIND_DATA;
                        n_crc      = crc_next;
                        n_shift    = {1'b0, r_shift[15:1]};
                        n_idx      = r_idx + 4'd1;
                        if (r_idx[2:0] == 3'd7) begin
                            n_idx = 4'd0;
                            if (r_last) begin
                                n_phase = hdlc_tx_pkg::PH_FCS;
                                n_shift = ~crc_next;
                            end else begin
                                done = 1'b1;
                            end
                        end
                    end
                    default: begin
                        cur_bit    = r_shift[0];
                        n_out_kind = hdlc_tx_pkg::KIND_FCS;
                        n_shift    = {1'b0, r_shift[15:1]};
                        n_idx      = r_idx + 4'd1;
                        if (r_idx == 4'd15) begin
                            n_idx   = 4'd0;
                            n_phase = hdlc_tx_pkg::PH_CLOSE;
                        end
                    end
                endcase

                n_out_bit = cur_bit;

                // Flag bits are never stuffed; data and FCS bits count ones.
                if (r_phase == hdlc_tx_pkg::PH_DATA || r_phase == hdlc_tx_pkg::PH_FCS) begin
                    if (cur_bit) begin
                        n_ones = ones_inc;
                        if (ones_inc == hdlc_tx_pkg::STUFF_RUN) begin
                            n_ones       = 3'd0;
                            n_stuff_pend = 1'b1;
                            n_pend_end   = done;
                        end
                    end else begin
                        n_ones = 3'd0;
                    end
                end

                if (n_stuff_pend) begin
                    n_out_end = 1'b0;
                    n_busy    = 1'b1;
                end else begin
                    n_out_end = done;
                    n_busy    = !done;
                end
            end
        end

        // Start the next word as soon as the serializer is free. The frame state seen
        // here already includes a closing flag that finishes in this cycle.
        load = r_hold_valid && !n_busy;
        if (load) begin
            n_hold_valid = 1'b0;
            n_busy       = 1'b1;
            n_idx        = 4'd0;
            n_shift      = {8'd0, r_hold_data};
            n_last       = r_hold_last;
            if (n_in_frame) begin
                n_phase = hdlc_tx_pkg::PH_DATA;
            end else begin
                n_phase = hdlc_tx_pkg::PH_OPEN;
                n_crc   = hdlc_tx_pkg::CRC_PRESET;
            end
            n_in_frame   = 1'b1;
        end

        if (i_s_tvalid && !r_hold_valid) begin
            n_hold_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_phase      <= hdlc_tx_pkg::PH_OPEN;
            r_idx        <= 4'd0;
            r_in_frame   <= 1'b0;
            r_ones       <= 3'd0;
            r_crc        <= hdlc_tx_pkg::CRC_PRESET;
            r_stuff_pend <= 1'b0;
            r_pend_end   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_busy       <= n_busy;
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_in_frame   <= n_in_frame;
            r_ones       <= n_ones;
            r_crc        <= n_crc;
            r_stuff_pend <= n_stuff_pend;
            r_pend_end   <= n_pend_end;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && !r_hold_valid) begin
            r_hold_data <= i_s_tdata;
            r_hold_last <= i_s_tlast;
        end
        r_shift    <= n_shift;
        r_last     <= n_last;
        r_out_bit  <= n_out_bit;
        r_out_kind <= n_out_kind;
        r_out_end  <= n_out_end;
    end

    // A closed frame always leaves the ones counter cleared and the CRC preset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_ones == 3'd0 && r_crc == hdlc_tx_pkg::CRC_PRESET))
        else $error("frame closed with stale stuffing or CRC state");

    // The ones counter never reaches the stuffing threshold between bits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones < hdlc_tx_pkg::STUFF_RUN)
        else $error("ones run reached stuffing threshold");

    // A pending stuffed zero always belongs to a word still being serialized.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuff_pend |-> r_busy)
        else $error("stuffed zero pending while serializer idle");

    // A stuffed bit on the output is always a zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == hdlc_tx_pkg::KIND_STUFF) |-> !r_out_bit)
        else $error("stuffed bit is not zero");

endmodule
